/* rtl/dual_wavelength_absorbance_unit_defines.svh */
// ----------------------------------------------------------------------------
// Dual-wavelength absorbance unit: assertion macros
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef DUAL_WAVELENGTH_ABSORBANCE_UNIT_DEFINES_SVH
`define DUAL_WAVELENGTH_ABSORBANCE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define DWA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwa check failed");

// Next-cycle implication, disabled in reset
`define DWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwa check failed");

`endif

/* rtl/dwa_pkg.sv */
// ----------------------------------------------------------------------------
// dwa_pkg
// Types and constants shared by the absorbance unit.
// ----------------------------------------------------------------------------
package dwa_pkg;

  localparam int AvgW  = 10;
  localparam int SumW  = 14;
  localparam int CntW  = 4;
  localparam int AbsW  = 16;
  localparam int LogFracBits = 28;
  // Significant bits of a detector reading
  localparam int ReadingBits = 10;

  // log10(2) scaled by 2^32
  localparam logic [30:0] Log10Two = 31'd1292913986;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_AVG  = 2'd1;
  localparam logic [1:0] ST_ZERO_BLUE = 2'd2;

  // Tag order: blank blue, blank green, sample blue, sample green
  typedef struct packed {
    logic                  done;
    logic [AvgW-1:0]       avg;
    logic [AvgW-1:0]       pavg;
    logic                  anew;
    logic [3:0][AvgW-1:0]  avgs;
  } job_t;

  typedef struct packed {
    logic            group_done;
    logic [AvgW-1:0] average;
    logic [AvgW-1:0] prev_average;
    logic            abs_new;
    logic [AbsW-1:0] abs_blue;
    logic [AbsW-1:0] abs_green;
    logic [AbsW-1:0] abs_ratio;
    logic [AbsW-1:0] prev_abs_blue;
    logic [AbsW-1:0] prev_abs_green;
    logic [AbsW-1:0] prev_abs_ratio;
    logic [1:0]      status;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

/* rtl/dwa_if.sv */
// ----------------------------------------------------------------------------
// dwa_in_if / dwa_out_if
// Valid/ready channels of the absorbance unit.
// ----------------------------------------------------------------------------
interface dwa_in_if import dwa_pkg::*;;
  logic            valid;
  logic            ready;
  logic            phase;
  logic            color;
  logic [AvgW-1:0] reading;
  modport source(output valid, phase, color, reading, input ready);
  modport sink(input valid, phase, color, reading, output ready);
endinterface

interface dwa_out_if import dwa_pkg::*;;
  logic            valid;
  logic            ready;
  logic            group_done;
  logic [AvgW-1:0] average;
  logic [AvgW-1:0] prev_average;
  logic            abs_new;
  logic [AbsW-1:0] abs_blue;
  logic [AbsW-1:0] abs_green;
  logic [AbsW-1:0] abs_ratio;
  logic [AbsW-1:0] prev_abs_blue;
  logic [AbsW-1:0] prev_abs_green;
  logic [AbsW-1:0] prev_abs_ratio;
  logic [1:0]      status;
  modport source(output valid, group_done, average, prev_average, abs_new, abs_blue,
                 abs_green, abs_ratio, prev_abs_blue, prev_abs_green, prev_abs_ratio,
                 status, input ready);
  modport sink(input valid, group_done, average, prev_average, abs_new, abs_blue,
               abs_green, abs_ratio, prev_abs_blue, prev_abs_green, prev_abs_ratio,
               status, output ready);
endinterface

/* rtl/dwa_front.sv */
// ----------------------------------------------------------------------------
// dwa_front
// Accumulates runs of readings per tag and stores run averages.
// ----------------------------------------------------------------------------
module dwa_front import dwa_pkg::*; #(
  parameter int RUN_LENGTH = 10
) (
  input  logic  clk,
  input  logic  rst,
  dwa_in_if.sink samples,
  input  logic  q_full,
  output logic  push,
  output job_t  job
);

  localparam int MaskW = (ReadingBits < AvgW) ? ReadingBits : AvgW;
  localparam logic [AvgW-1:0] RdMask = AvgW'((1 << MaskW) - 1);
  // Divide by the run length as a multiply by its rounded-up reciprocal;
  // exact for every sum the run can reach
  localparam int RecipShift = 20;
  localparam logic [RecipShift:0] RecipM =
    (RecipShift+1)'(((1 << RecipShift) + RUN_LENGTH - 1) / RUN_LENGTH);

  logic [SumW-1:0]      run_sum;
  logic [CntW-1:0]      run_count;
  logic [1:0]           run_tag;
  logic [3:0][AvgW-1:0] averages;

  logic [1:0]      tag;
  logic            same;
  logic [SumW-1:0] sum_next;
  logic [CntW-1:0] count_next;
  logic            done;
  logic [SumW+RecipShift:0] avg_prod;
  logic [AvgW-1:0] avg;

  assign samples.ready = !q_full;
  assign push          = samples.valid && !q_full;

  always_comb begin
    tag        = {samples.phase, samples.color};
    same       = (tag == run_tag);
    sum_next   = (same ? run_sum : '0) + SumW'(samples.reading & RdMask);
    count_next = (same ? run_count : '0) + CntW'(1);
    done       = (count_next >= CntW'(RUN_LENGTH));
    avg_prod   = sum_next * RecipM;
    avg        = avg_prod[RecipShift +: AvgW];
    job.done   = done;
    job.avg    = done ? avg : '0;
    job.pavg   = done ? averages[tag] : '0;
    job.anew   = done && (tag == 2'd3);
    for (int i = 0; i < 4; i++) begin
      job.avgs[i] = (done && tag == 2'(i)) ? avg : averages[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum   <= '0;
      run_count <= '0;
      run_tag   <= '0;
      averages  <= '0;
    end else if (push) begin
      run_tag <= tag;
      if (done) begin
        run_sum       <= '0;
        run_count     <= '0;
        averages[tag] <= avg;
      end else begin
        run_sum   <= sum_next;
        run_count <= count_next;
      end
    end
  end

endmodule

/* rtl/dwa_queue.sv */
// ----------------------------------------------------------------------------
// dwa_queue
// Two-entry queue of jobs between front and back.
// ----------------------------------------------------------------------------
module dwa_queue import dwa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  q_ctl_t ctl,
  input  job_t   wr_job,
  output job_t   rd_job,
  output logic   full,
  output logic   not_empty
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (ctl.push) wr_ptr <= !wr_ptr;
      if (ctl.pop)  rd_ptr <= !rd_ptr;
      case ({ctl.push, ctl.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/dwa_back.sv */
// ----------------------------------------------------------------------------
// dwa_back
// Computes absorbances and ratio with a shared squarer and a serial divider.
// ----------------------------------------------------------------------------
module dwa_back import dwa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  input  job_t q_job,
  output logic pop,
  dwa_out_if.source results
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOG  = 6'b000010,
    S_MUL  = 6'b000100,
    S_RND  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } back_state_t;

  back_state_t state;
  job_t        job;
  logic [2:0][AbsW-1:0] cur_abs;
  logic [2:0][AbsW-1:0] prev_abs;
  logic [1:0]  opnd;
  logic [4:0]  step;
  logic [31:0] mant;
  logic [3:0]  lg_n;
  logic [LogFracBits-1:0] frac;
  logic [3:0][31:0] logs;
  logic        chan;
  logic [62:0] prod;
  logic        prod_neg;
  logic [16:0] div_rem;
  logic [24:0] div_q;
  logic [24:0] div_d;
  logic [16:0] div_dv;
  logic        div_neg;
  logic [4:0]  div_cnt;
  res_t        res;
  logic        res_valid;

  logic        slot_free;
  logic        res_load;
  logic [AvgW-1:0] x_raw;
  logic [AvgW-1:0] x0;
  logic [3:0]  x_n;
  logic [40:0] x_sh;
  logic [63:0] sq;
  logic [LogFracBits-1:0] frac_next;
  logic [31:0] mant_next;
  logic [31:0] lb;
  logic [31:0] ls;
  logic        l_neg;
  logic [31:0] l_diff;
  logic [63:0] rnd_sum;
  logic [15:0] rnd_q;
  logic [AbsW-1:0] rnd_val;
  logic [AvgW-1:0] blank_avg;
  logic [AvgW-1:0] sample_avg;
  logic [16:0] r2;
  logic        r_ge;
  logic [15:0] green_mag;
  logic [15:0] blue_mag;
  logic [AbsW-1:0] ratio_val;
  logic [1:0]  status_val;

  assign slot_free = !res_valid || results.ready;
  assign pop       = (state == S_IDLE) && q_not_empty && slot_free;
  // Load the result register with a plain word or a finished absorbance set
  assign res_load  = (pop && !q_job.anew) || ((state == S_OUT) && slot_free);

  always_comb begin
    // Operand order: blank blue, sample blue, blank green, sample green
    x_raw = job.avgs[{opnd[0], opnd[1]}];
    x0    = (x_raw == '0) ? AvgW'(1) : x_raw;
    x_n   = '0;
    for (int i = 0; i < AvgW; i++) begin
      if (x0[i]) x_n = 4'(i);
    end
    x_sh = {x0, 31'b0} >> x_n;
    sq   = mant * mant;
    if (sq[63]) begin
      mant_next = sq[63:32];
      frac_next = {frac[LogFracBits-2:0], 1'b1};
    end else begin
      mant_next = sq[62:31];
      frac_next = {frac[LogFracBits-2:0], 1'b0};
    end

    lb     = logs[{chan, 1'b0}];
    ls     = logs[{chan, 1'b1}];
    l_neg  = (ls > lb);
    l_diff = l_neg ? (ls - lb) : (lb - ls);

    rnd_sum    = {1'b0, prod} + 64'h0000_8000_0000_0000;
    rnd_q      = rnd_sum[63:48];
    blank_avg  = job.avgs[{1'b0, chan}];
    sample_avg = job.avgs[{1'b1, chan}];
    if (blank_avg == '0 && sample_avg == '0) begin
      rnd_val = '0;
    end else if (sample_avg == '0) begin
      rnd_val = 16'h7FFF;
    end else if (blank_avg == '0) begin
      rnd_val = 16'h8000;
    end else if (rnd_q[15]) begin
      rnd_val = prod_neg ? 16'h8000 : 16'h7FFF;
    end else begin
      rnd_val = prod_neg ? 16'(~rnd_q + 16'd1) : rnd_q;
    end

    r2   = {div_rem[15:0], div_d[24]};
    r_ge = (r2 >= div_dv);
    green_mag = cur_abs[1][15] ? 16'(~cur_abs[1] + 16'd1) : cur_abs[1];
    blue_mag  = cur_abs[0][15] ? 16'(~cur_abs[0] + 16'd1) : cur_abs[0];
    if (div_neg) begin
      ratio_val = (div_q >= 25'd32768) ? 16'h8000 : 16'(~div_q[15:0] + 16'd1);
    end else begin
      ratio_val = (div_q >= 25'd32767) ? 16'h7FFF : div_q[15:0];
    end

    if (job.avgs[0] == '0 || job.avgs[1] == '0 || job.avgs[2] == '0 ||
        job.avgs[3] == '0) begin
      status_val = ST_ZERO_AVG;
    end else if (cur_abs[0] == '0) begin
      status_val = ST_ZERO_BLUE;
    end else begin
      status_val = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      cur_abs   <= '0;
      prev_abs  <= '0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (results.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            job <= q_job;
            if (q_job.anew) begin
              prev_abs <= cur_abs;
              opnd     <= '0;
              step     <= '0;
              state    <= S_LOG;
            end else begin
              res.group_done     <= q_job.done;
              res.average        <= q_job.avg;
              res.prev_average   <= q_job.pavg;
              res.abs_new        <= 1'b0;
              res.abs_blue       <= cur_abs[0];
              res.abs_green      <= cur_abs[1];
              res.abs_ratio      <= cur_abs[2];
              res.prev_abs_blue  <= prev_abs[0];
              res.prev_abs_green <= prev_abs[1];
              res.prev_abs_ratio <= prev_abs[2];
              res.status         <= ST_OK;
            end
          end
        end
        S_LOG: begin
          if (step == 5'd0) begin
            mant <= x_sh[31:0];
            lg_n <= x_n;
            frac <= '0;
            step <= 5'd1;
          end else begin
            mant <= mant_next;
            frac <= frac_next;
            if (step == 5'(LogFracBits)) begin
              logs[opnd] <= {lg_n, frac_next};
              step       <= '0;
              if (opnd == 2'd3) begin
                chan  <= 1'b0;
                state <= S_MUL;
              end else begin
                opnd <= opnd + 2'd1;
              end
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        S_MUL: begin
          prod     <= l_diff * Log10Two;
          prod_neg <= l_neg;
          state    <= S_RND;
        end
        S_RND: begin
          cur_abs[chan] <= rnd_val;
          if (chan) begin
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            chan  <= 1'b1;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_cnt == 5'd0) begin
            if (cur_abs[0] == '0) begin
              if (cur_abs[1] == '0)    cur_abs[2] <= '0;
              else if (cur_abs[1][15]) cur_abs[2] <= 16'h8000;
              else                     cur_abs[2] <= 16'h7FFF;
              state <= S_OUT;
            end else begin
              // Round to nearest: (2n + d) / 2d
              div_d   <= {green_mag, 9'b0} + 25'(blue_mag);
              div_dv  <= {blue_mag, 1'b0};
              div_rem <= '0;
              div_q   <= '0;
              div_neg <= cur_abs[1][15] != cur_abs[0][15];
              div_cnt <= 5'd1;
            end
          end else if (div_cnt == 5'd26) begin
            cur_abs[2] <= ratio_val;
            state      <= S_OUT;
          end else begin
            div_rem <= r_ge ? (r2 - div_dv) : r2;
            div_q   <= {div_q[23:0], r_ge};
            div_d   <= {div_d[23:0], 1'b0};
            div_cnt <= div_cnt + 5'd1;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            res.group_done     <= job.done;
            res.average        <= job.avg;
            res.prev_average   <= job.pavg;
            res.abs_new        <= 1'b1;
            res.abs_blue       <= cur_abs[0];
            res.abs_green      <= cur_abs[1];
            res.abs_ratio      <= cur_abs[2];
            res.prev_abs_blue  <= prev_abs[0];
            res.prev_abs_green <= prev_abs[1];
            res.prev_abs_ratio <= prev_abs[2];
            res.status         <= status_val;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid          = res_valid;
  assign results.group_done     = res.group_done;
  assign results.average        = res.average;
  assign results.prev_average   = res.prev_average;
  assign results.abs_new        = res.abs_new;
  assign results.abs_blue       = res.abs_blue;
  assign results.abs_green      = res.abs_green;
  assign results.abs_ratio      = res.abs_ratio;
  assign results.prev_abs_blue  = res.prev_abs_blue;
  assign results.prev_abs_green = res.prev_abs_green;
  assign results.prev_abs_ratio = res.prev_abs_ratio;
  assign results.status         = res.status;

endmodule

/* rtl/dual_wavelength_absorbance_unit.sv */
// ----------------------------------------------------------------------------
// dual_wavelength_absorbance_unit
// Run averaging of tagged detector words and log-ratio absorbance.
// ----------------------------------------------------------------------------
//  channel   dir  handshake    word
//  samples   in   valid/ready  phase, color, reading
//  results   out  valid/ready  averages, absorbances, ratio, status
//
//  An ordinary word passes the front combinationally, is written into the
//  queue and then registered in the result register. A word that completes
//  a sample-green run takes the back through four 28-step logs on one shared
//  squarer, two multiply/round passes and a 25-step serial divide.
//  The two-entry queue takes up to two more words meanwhile, then the front
//  drops ready until the back frees a slot.
//  Synchronous reset clears runs, averages and absorbance sets.
// ----------------------------------------------------------------------------
module dual_wavelength_absorbance_unit import dwa_pkg::*; #(
  parameter int RUN_LENGTH = 10
) (
  input  logic       clk,
  input  logic       rst,
  dwa_in_if.sink     samples,
  dwa_out_if.source  results
);

  job_t   front_job;
  job_t   back_job;
  q_ctl_t q_ctl;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_not_empty;

  assign q_ctl = '{push: q_push, pop: q_pop};

  // Front: accumulate runs and push one job per word
  dwa_front #(
    .RUN_LENGTH(RUN_LENGTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .samples(samples),
    .q_full (q_full),
    .push   (q_push),
    .job    (front_job)
  );

  // Hold jobs while the back is busy with a log/divide sequence
  dwa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (q_ctl),
    .wr_job   (front_job),
    .rd_job   (back_job),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  // Back: compute absorbances and drive the result register
  dwa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_job      (back_job),
    .pop        (q_pop),
    .results    (results)
  );

endmodule

/* rtl/dwa_checker.sv */
// ----------------------------------------------------------------------------
// dwa_checker
// Port-level checks on the result channel of the absorbance unit.
// ----------------------------------------------------------------------------
`include "dual_wavelength_absorbance_unit_defines.svh"

module dwa_checker import dwa_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_ready,
  input logic            group_done,
  input logic            abs_new,
  input logic [AvgW-1:0] average,
  input logic [AvgW-1:0] prev_average,
  input logic [1:0]      status
);

  `DWA_ASSERT_NEXT(a_hold_valid, res_valid && !res_ready, res_valid)
  `DWA_ASSERT_NOW(a_new_needs_done, res_valid && abs_new, group_done)
  `DWA_ASSERT_NOW(a_status_quiet, res_valid && !abs_new, status == ST_OK)
  `DWA_ASSERT_NOW(a_avg_quiet, res_valid && !group_done,
                  average == '0 && prev_average == '0)

endmodule

bind dual_wavelength_absorbance_unit dwa_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .group_done  (results.group_done),
  .abs_new     (results.abs_new),
  .average     (results.average),
  .prev_average(results.prev_average),
  .status      (results.status)
);
